>>> rtl/core/isbn10v_pkg.sv
// ----------------------------------------------------------------------------
// isbn10v_pkg
// Shared types, character codes and the modulo-eleven helper for the
// hyphenated ISBN-10 line checker.
// ----------------------------------------------------------------------------
package isbn10v_pkg;

    localparam logic [7:0] CH_HYPHEN  = 8'h2D;
    localparam logic [7:0] CH_X       = 8'h58;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    localparam logic [3:0] MODULUS      = 4'd11;
    localparam logic [3:0] CHECK_VALUE_X = 4'd10;
    localparam logic [3:0] TOP_WEIGHT   = 4'd10;
    localparam logic [3:0] LIMIT_G0     = 4'd5;
    localparam logic [3:0] LIMIT_G1     = 4'd7;
    localparam logic [3:0] LIMIT_G2     = 4'd6;

    localparam logic [2:0] HYPHENS_NEEDED = 3'd3;
    localparam logic [2:0] HYPHEN_SAT     = 3'd4;
    localparam logic [3:0] GROUP_SAT      = 4'd8;
    localparam logic [3:0] DIGITS_NEEDED  = 4'd9;
    localparam logic [3:0] DIGIT_SAT      = 4'd10;

    // floor(v / 11) = (v * 187) >> 11 for every v up to 100
    localparam logic [7:0] MOD11_RECIP = 8'd187;
    localparam int         MOD11_SHIFT = 11;

    typedef struct packed {
        logic       is_digit;
        logic       is_hyphen;
        logic       is_letter;
        logic       is_x;
        logic [3:0] digit;
    } char_class_t;

    function automatic logic [3:0] mod11(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  quot;
        logic [6:0]  back;
        prod = 15'(v) * 15'(MOD11_RECIP);
        quot = prod[14:MOD11_SHIFT];
        back = 7'(quot * MODULUS);
        return 4'(v - back);
    endfunction

endpackage

>>> rtl/core/isbn10_hyphenated_validator_top.sv
// a line's verdict is registered as its last character moves on
// throughput: one character per cycle; a last character waits while the
// previous result is still untaken
// the rate is set by the line-state update between the character
// register and the result register
// reset: aresetn clears the line state and empties both register stages
// ----------------------------------------------------------------------------
// isbn10_hyphenated_validator_top
// Checks a hyphenated ISBN-10 line, one character per request, and returns
// one valid flag per line on its last character.
// ----------------------------------------------------------------------------
module isbn10_hyphenated_validator_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_code,
    input  logic       s_end_of_line,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_valid_res
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] char_reg;
    logic       eol_reg;
    logic       out_valid_reg, out_valid_next;
    logic       res_reg;

    logic                     advance;
    logic                     line_ok;
    isbn10v_pkg::char_class_t char_class;

    // a last character needs a free result slot; others move on at once
    assign advance = in_valid_reg && (!eol_reg || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    isbn10v_class u_class (
        .char_code  (char_reg),
        .char_class (char_class)
    );

    isbn10v_line u_line (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .end_of_line (eol_reg),
        .char_class  (char_class),
        .line_ok     (line_ok)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance && eol_reg) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            char_reg <= s_char_code;
            eol_reg  <= s_end_of_line;
        end
        if (advance && eol_reg) begin
            res_reg <= line_ok;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_valid_res = res_reg;

endmodule

>>> rtl/core/isbn10v_class.sv
// ----------------------------------------------------------------------------
// isbn10v_class
// Sorts one character into digit, hyphen, letter and check-letter classes
// and extracts the digit value.
// ----------------------------------------------------------------------------
module isbn10v_class (
    input  logic [7:0]                char_code,
    output isbn10v_pkg::char_class_t  char_class
);

    logic [7:0] offset;

    assign offset = char_code - isbn10v_pkg::CH_ZERO;

    always_comb begin
        char_class.is_digit  = (char_code >= isbn10v_pkg::CH_ZERO) &&
                               (char_code <= isbn10v_pkg::CH_NINE);
        char_class.is_hyphen = (char_code == isbn10v_pkg::CH_HYPHEN);
        char_class.is_letter = ((char_code >= isbn10v_pkg::CH_UPPER_A) &&
                                (char_code <= isbn10v_pkg::CH_UPPER_Z)) ||
                               ((char_code >= isbn10v_pkg::CH_LOWER_A) &&
                                (char_code <= isbn10v_pkg::CH_LOWER_Z));
        char_class.is_x      = (char_code == isbn10v_pkg::CH_X);
        char_class.digit     = offset[3:0];
    end

endmodule

>>> rtl/core/isbn10v_line.sv
// ----------------------------------------------------------------------------
// isbn10v_line
// Per-line state: hyphen and group counters, digit count, weighted sum
// modulo eleven and the sticky format error; gives the verdict on the
// last character.
// ----------------------------------------------------------------------------
module isbn10v_line (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      step,
    input  logic                      end_of_line,
    input  isbn10v_pkg::char_class_t  char_class,
    output logic                      line_ok
);

    logic [2:0] hyphen_count_reg,   hyphen_count_next;
    logic [3:0] group_length_reg,   group_length_next;
    logic [3:0] digit_count_reg,    digit_count_next;
    logic [3:0] sum_mod_eleven_reg, sum_mod_eleven_next;
    logic       format_error_reg,   format_error_next;

    logic [3:0] group_limit;
    logic [3:0] weight;
    logic [6:0] weighted_sum;
    logic [3:0] check_value;
    logic       have_check;
    logic [4:0] check_total;

    always_comb begin
        unique case (hyphen_count_reg)
            3'd0:    group_limit = isbn10v_pkg::LIMIT_G0;
            3'd1:    group_limit = isbn10v_pkg::LIMIT_G1;
            3'd2:    group_limit = isbn10v_pkg::LIMIT_G2;
            default: group_limit = 4'd0;
        endcase
    end

    assign weight       = isbn10v_pkg::TOP_WEIGHT - digit_count_reg;
    assign weighted_sum = 7'(sum_mod_eleven_reg) + 7'(char_class.digit * weight);

    always_comb begin
        hyphen_count_next   = hyphen_count_reg;
        group_length_next   = group_length_reg;
        digit_count_next    = digit_count_reg;
        sum_mod_eleven_next = sum_mod_eleven_reg;
        format_error_next   = format_error_reg;
        if (step) begin
            if (end_of_line) begin
                hyphen_count_next   = '0;
                group_length_next   = '0;
                digit_count_next    = '0;
                sum_mod_eleven_next = '0;
                format_error_next   = 1'b0;
            end else if (char_class.is_hyphen) begin
                // empty group, fourth hyphen or overlong group
                if ((group_length_reg == 4'd0) ||
                    (hyphen_count_reg >= isbn10v_pkg::HYPHENS_NEEDED) ||
                    (group_length_reg > group_limit)) begin
                    format_error_next = 1'b1;
                end
                if (hyphen_count_reg < isbn10v_pkg::HYPHEN_SAT) begin
                    hyphen_count_next = hyphen_count_reg + 3'd1;
                end
                group_length_next = '0;
            end else begin
                if (char_class.is_letter) begin
                    format_error_next = 1'b1;
                end
                if (group_length_reg < isbn10v_pkg::GROUP_SAT) begin
                    group_length_next = group_length_reg + 4'd1;
                end
                if (char_class.is_digit) begin
                    if (digit_count_reg < isbn10v_pkg::DIGITS_NEEDED) begin
                        sum_mod_eleven_next = isbn10v_pkg::mod11(weighted_sum);
                    end
                    if (digit_count_reg < isbn10v_pkg::DIGIT_SAT) begin
                        digit_count_next = digit_count_reg + 4'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hyphen_count_reg   <= '0;
            group_length_reg   <= '0;
            digit_count_reg    <= '0;
            sum_mod_eleven_reg <= '0;
            format_error_reg   <= 1'b0;
        end else begin
            hyphen_count_reg   <= hyphen_count_next;
            group_length_reg   <= group_length_next;
            digit_count_reg    <= digit_count_next;
            sum_mod_eleven_reg <= sum_mod_eleven_next;
            format_error_reg   <= format_error_next;
        end
    end

    // check digit, X stands for ten
    assign have_check  = char_class.is_digit || char_class.is_x;
    assign check_value = char_class.is_digit ? char_class.digit : isbn10v_pkg::CHECK_VALUE_X;
    assign check_total = 5'(sum_mod_eleven_reg) + 5'(check_value);

    assign line_ok = !format_error_reg &&
                     (hyphen_count_reg == isbn10v_pkg::HYPHENS_NEEDED) &&
                     (group_length_reg == 4'd0) &&
                     (digit_count_reg == isbn10v_pkg::DIGITS_NEEDED) &&
                     have_check &&
                     ((check_total == 5'd0) || (check_total == 5'(isbn10v_pkg::MODULUS)));

endmodule
